// ===== rtl/sah_pkg.sv =====
package sah_pkg;

  // Table geometry
  localparam int SLOTS        = 2048;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int ADDR_BITS    = 64;
  localparam int KEY_W        = ADDR_BITS;
  localparam int CNT_W        = 32;
  localparam int ENTRY_W      = KEY_W + CNT_W;

  // Fixed field widths at the ports
  localparam int PC_W         = 64;
  localparam int SLOT_FIELD_W = 11;
  localparam int STATUS_W     = 2;

  // Multiplicative hash
  localparam logic [31:0] HASH_MULT  = 32'd2654435761;
  localparam int          HASH_SHIFT = 4;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH  = 2;

  // Commands
  localparam logic CMD_NOTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ = 2'd3;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    OP_READ,
    OP_NOTE,
    OP_DROP
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [KEY_W-1:0]     pc;
    logic [SLOT_W-1:0]    slot;  // home slot for notes, target slot for reads
  } op_t;

  // Slot index to the port field width
  function automatic logic [SLOT_FIELD_W-1:0] to_slot_field(input logic [SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SLOT_FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/sah_in_if.sv =====
interface sah_in_if;
  import sah_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [PC_W-1:0]             pc;
  logic [SLOT_FIELD_W-1:0]     read_slot;

  modport source (output valid, output cmd, output pc, output read_slot, input ready);
  modport sink   (input valid, input cmd, input pc, input read_slot, output ready);
endinterface

// ===== rtl/sah_out_if.sv =====
interface sah_out_if;
  import sah_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic [SLOT_FIELD_W-1:0]     slot;
  logic [PC_W-1:0]             key;
  logic [CNT_W-1:0]            count;

  modport source (output valid, output status, output slot, output key, output count,
                  input ready);
  modport sink   (input valid, input status, input slot, input key, input count,
                  output ready);
endinterface

// ===== rtl/sample_address_histogram_core.sv =====
// Counts sampled program addresses in a 2048-slot open-addressing hash table
// with linear probing, and reads back single slots for a dump. After reset
// the table is swept to empty, one slot per cycle; req.ready stays low
// during that pass. The front decodes and hashes each item in the cycle it
// is accepted, with no added latency, and the item is queued two deep, so
// new items keep arriving while the back end works or a result waits on rsp,
// until the queue is full. The back end takes the oldest queued item once it
// is idle and the result register is free. A note probes from its home slot
// until it finds its key or an empty slot, up to all 2048 slots; if none is
// found it is dropped. The table has one registered read port, so probing
// runs at one slot per cycle. A zero address is dropped without touching the
// table.
module sample_address_histogram_core (
  input  logic       clk,
  input  logic       rst,
  sah_in_if.sink     req,
  sah_out_if.source  rsp
);
  import sah_pkg::*;

  logic clearing;
  logic q_full;
  logic push;
  op_t  push_op;
  logic q_avail;
  logic q_pop;
  op_t  q_op;

  sah_front u_front (
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op),
    .req      (req)
  );

  sah_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .avail   (q_avail),
    .pop_op  (q_op)
  );

  sah_back u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_avail  (q_avail),
    .q_op     (q_op),
    .q_pop    (q_pop),
    .rsp      (rsp)
  );

endmodule

// ===== rtl/sah_ram.sv =====
module sah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/sah_queue.sv =====
module sah_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sah_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output sah_pkg::op_t  pop_op
);
  import sah_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  op_t               entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] cnt;

  assign full   = (cnt == CNT_QW'(QUEUE_DEPTH));
  assign avail  = (cnt != '0);
  assign pop_op = entries[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && avail) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && avail)) begin
        cnt <= cnt + 1'b1;
      end else if (!(push && !full) && (pop && avail)) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_QW'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");
`endif

endmodule

// ===== rtl/sah_front.sv =====
module sah_front (
  input  logic          clearing,
  input  logic          q_full,
  output logic          push,
  output sah_pkg::op_t  push_op,
  sah_in_if.sink        req
);
  import sah_pkg::*;

  logic [KEY_W-1:0]  pc_m;
  logic [PC_W-1:0]   pc_x;
  logic [PC_W-1:0]   pc_sh;
  logic [SLOT_W-1:0] home;
  logic [31:0]       rs_x;

  // Items are taken only once the table is cleared and the queue has room
  assign req.ready = !clearing && !q_full;
  assign push      = req.valid && req.ready;

  // Home slot: only the low slot bits of the product are needed
  assign pc_m  = req.pc[KEY_W-1:0];
  assign pc_x  = PC_W'(pc_m);
  assign pc_sh = pc_x >> HASH_SHIFT;
  assign home  = SLOT_W'(pc_sh[SLOT_W-1:0] * HASH_MULT[SLOT_W-1:0]);
  assign rs_x  = 32'(req.read_slot);

  // Classify the item
  always_comb begin
    push_op.pc = pc_m;
    if (req.cmd == CMD_READ) begin
      push_op.kind = OP_READ;
      push_op.slot = rs_x[SLOT_W-1:0];
    end else if (pc_m == '0) begin
      push_op.kind = OP_DROP;
      push_op.slot = home;
    end else begin
      push_op.kind = OP_NOTE;
      push_op.slot = home;
    end
  end

endmodule

// ===== rtl/sah_back.sv =====
module sah_back (
  input  logic          clk,
  input  logic          rst,
  output logic          clearing,
  input  logic          q_avail,
  input  sah_pkg::op_t  q_op,
  output logic          q_pop,
  sah_out_if.source     rsp
);
  import sah_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t              state;
  op_t                 op;
  logic [SLOT_W-1:0]   cur;
  logic [SLOT_W-1:0]   probes;
  logic [SLOT_W-1:0]   clr_addr;

  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [KEY_W-1:0]    res_key;
  logic [CNT_W-1:0]    res_count;

  logic                out_free;
  logic                start;
  logic                res_load;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [SLOT_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  logic [KEY_W-1:0]    rd_key;
  logic [CNT_W-1:0]    rd_cnt;
  logic [CNT_W-1:0]    new_cnt;
  logic                hit;
  logic                empty;
  logic                last;

  sah_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign clearing = (state == S_CLEAR);
  assign out_free = !res_valid || rsp.ready;
  assign start    = (state == S_IDLE) && q_avail && out_free;
  assign q_pop    = start;

  // Probe compare on the registered read data
  assign rd_key  = rd_data[ENTRY_W-1:CNT_W];
  assign rd_cnt  = rd_data[CNT_W-1:0];
  assign hit     = (rd_key == op.pc);
  assign empty   = (rd_key == '0);
  assign last    = (probes == SLOT_W'(SLOTS - 1));
  assign new_cnt = hit ? ((rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1) : CNT_W'(1);

  // Table port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = {op.pc, new_cnt};
    rd_addr = cur + 1'b1;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_addr = q_op.slot;
      end
      S_LOOK: begin
        wr_en = (op.kind == OP_NOTE) && (hit || empty);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign res_load = (start && q_op.kind == OP_DROP) ||
                    ((state == S_LOOK) && ((op.kind != OP_NOTE) || hit || empty || last));

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && rsp.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op     <= q_op;
            cur    <= q_op.slot;
            probes <= '0;
            if (q_op.kind == OP_DROP) begin
              res_valid  <= 1'b1;
              res_status <= ST_DROP;
              res_slot   <= q_op.slot;
              res_key    <= '0;
              res_count  <= '0;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (op.kind != OP_NOTE) begin
            res_valid  <= 1'b1;
            res_status <= ST_READ;
            res_slot   <= cur;
            res_key    <= rd_key;
            res_count  <= rd_cnt;
            state      <= S_IDLE;
          end else if (hit || empty) begin
            res_valid  <= 1'b1;
            res_status <= hit ? ST_HIT : ST_NEW;
            res_slot   <= cur;
            res_key    <= op.pc;
            res_count  <= new_cnt;
            state      <= S_IDLE;
          end else if (last) begin
            // every slot probed: drop against the home slot
            res_valid  <= 1'b1;
            res_status <= ST_DROP;
            res_slot   <= op.slot;
            res_key    <= '0;
            res_count  <= '0;
            state      <= S_IDLE;
          end else begin
            cur    <= cur + 1'b1;
            probes <= probes + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = res_valid;
  assign rsp.status = res_status;
  assign rsp.slot   = to_slot_field(res_slot);
  assign rsp.key    = PC_W'(res_key);
  assign rsp.count  = res_count;

`ifndef ASSERT_OFF
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !res_valid)
    else $error("result presented during clearing pass");
`endif
`ifndef ASSERT_OFF
  a_write_ends_op: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOOK) && wr_en) |=> (state == S_IDLE) && res_valid)
    else $error("table update did not finish the item");
`endif
`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result register overwritten while occupied");
`endif
`ifndef ASSERT_OFF
  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && q_avail)
    else $error("queue popped outside idle");
`endif

endmodule
